// ----- hw/rtl/bpf64_pkg.sv -----
`default_nettype none

package bpf64_pkg;

    localparam int SCRATCH_WORDS_DEF = 16;
    localparam int COLUMN_SLOTS_DEF  = 64;
    localparam int RECORD_SLOTS_DEF  = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_WIDTH = 8'd1;

    localparam logic [1:0] ACT_EXEC      = 2'd0;
    localparam logic [1:0] ACT_COL_WRITE = 2'd1;
    localparam logic [1:0] ACT_REC_WRITE = 2'd2;
    localparam logic [1:0] ACT_REC_READ  = 2'd3;

    localparam logic [2:0] CLS_LD   = 3'd0;
    localparam logic [2:0] CLS_LDX  = 3'd1;
    localparam logic [2:0] CLS_ST   = 3'd2;
    localparam logic [2:0] CLS_STX  = 3'd3;
    localparam logic [2:0] CLS_ALU  = 3'd4;
    localparam logic [2:0] CLS_JMP  = 3'd5;
    localparam logic [2:0] CLS_RET  = 3'd6;
    localparam logic [2:0] CLS_MISC = 3'd7;

    localparam logic [2:0] MODE_IMM = 3'd0;
    localparam logic [2:0] MODE_ABS = 3'd1;
    localparam logic [2:0] MODE_IND = 3'd2;
    localparam logic [2:0] MODE_MEM = 3'd3;
    localparam logic [2:0] MODE_REC = 3'd6;

    localparam logic [3:0] ALU_ADD = 4'h0;
    localparam logic [3:0] ALU_SUB = 4'h1;
    localparam logic [3:0] ALU_MUL = 4'h2;
    localparam logic [3:0] ALU_DIV = 4'h3;
    localparam logic [3:0] ALU_OR  = 4'h4;
    localparam logic [3:0] ALU_AND = 4'h5;
    localparam logic [3:0] ALU_LSH = 4'h6;
    localparam logic [3:0] ALU_RSH = 4'h7;
    localparam logic [3:0] ALU_NEG = 4'h8;

    localparam logic [3:0] JMP_JA   = 4'h0;
    localparam logic [3:0] JMP_JEQ  = 4'h1;
    localparam logic [3:0] JMP_JGT  = 4'h2;
    localparam logic [3:0] JMP_JGE  = 4'h3;
    localparam logic [3:0] JMP_JSET = 4'h4;

    localparam logic [1:0] RVAL_K = 2'd0;
    localparam logic [1:0] RVAL_X = 2'd1;
    localparam logic [1:0] RVAL_A = 2'd2;

    localparam logic [4:0] MISC_TAX = 5'h00;
    localparam logic [4:0] MISC_TXA = 5'h10;
    localparam logic [4:0] MISC_LDR = 5'h08;
    localparam logic [4:0] MISC_STR = 5'h09;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_STORE = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_ENC   = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;
    localparam logic [1:0] ERR_DIV0  = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        opcode;
        logic [31:0]        operand_k;
        logic [7:0]         jump_true;
        logic [7:0]         jump_false;
        logic [5:0]         slot_index;
        logic signed [63:0] word_value;
    } in_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               finished;
        logic signed [63:0] return_value;
        logic [1:0]         misc_request;
        logic [1:0]         error_code;
        logic signed [63:0] read_value;
    } out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bpf64_instruction_executor.sv -----
// sequence: accept in IDLE, then DEC, EXEC and WB; mul and div loop in their own states, one
// bit per cycle through the shared adder, and div passes FIN for the sign fix
// throughput: one transaction at a time, input ready only while the sequencer is idle
// reset: aresetn synchronous active low, clears A, X, pc, config, scratch and record
// valid bits; column store is undefined until written, no clearing pass
`default_nettype none

module bpf64_instruction_executor #(
    parameter int SCRATCH_WORDS = bpf64_pkg::SCRATCH_WORDS_DEF,
    parameter int COLUMN_SLOTS  = bpf64_pkg::COLUMN_SLOTS_DEF,
    parameter int RECORD_SLOTS  = bpf64_pkg::RECORD_SLOTS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire bpf64_pkg::in_t                    s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output bpf64_pkg::out_t                        m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bpf64_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bpf64_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SCR_AW = (SCRATCH_WORDS > 1) ? $clog2(SCRATCH_WORDS) : 1;
    localparam int COL_AW = (COLUMN_SLOTS > 1) ? $clog2(COLUMN_SLOTS) : 1;
    localparam int REC_AW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DEC  = 7'b0000010,
        ST_EXEC = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_WB   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    bpf64_pkg::in_t  ins_reg;
    bpf64_pkg::out_t res_reg, res_next;
    bpf64_pkg::out_t out_reg;
    logic            m_valid_reg;

    logic [63:0] a_reg, a_next;
    logic [63:0] x_reg, x_next;
    logic [15:0] pc_reg, pc_next;
    logic [6:0]  column_count_reg;
    logic [4:0]  record_width_reg;

    logic [63:0] wp_reg, wp_next;
    logic [63:0] wq_reg, wq_next;
    logic [63:0] wd_reg, wd_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;

    logic [64:0] add_x, add_y, add_sum;
    logic        add_ci;

    logic [63:0] scr_mem [SCRATCH_WORDS];
    logic [63:0] col_mem [COLUMN_SLOTS];
    logic [63:0] rec_mem [RECORD_SLOTS];
    logic [SCRATCH_WORDS-1:0] scr_vld_reg;
    logic [RECORD_SLOTS-1:0]  rec_vld_reg;

    logic [63:0] scr_rd_reg, col_rd_reg, rec_rd_reg;
    logic        scr_rdv_reg, rec_rdv_reg;
    logic        col_ok_reg, scr_ok_reg, rec_ok_reg;

    logic [63:0]       k64, col_idx;
    logic [SCR_AW-1:0] scr_addr;
    logic [COL_AW-1:0] col_raddr, col_waddr;
    logic [REC_AW-1:0] rec_addr;
    logic              col_ok_c, scr_ok_c, rec_ok_c;
    logic              scr_we, col_we, rec_we, scr_clr;
    logic [63:0]       wr_data;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    assign add_sum = add_x + add_y + 65'(add_ci);

    // address generation and range checks, registered with the memory reads
    always_comb begin
        k64       = {32'd0, ins_reg.operand_k};
        col_idx   = (ins_reg.opcode[7:5] == bpf64_pkg::MODE_IND) ? (x_reg + k64) : k64;
        col_ok_c  = (col_idx < 64'(column_count_reg)) && (col_idx < 64'(COLUMN_SLOTS));
        scr_ok_c  = k64 < 64'(SCRATCH_WORDS);
        scr_addr  = ins_reg.operand_k[SCR_AW-1:0];
        col_raddr = col_idx[COL_AW-1:0];
        col_waddr = COL_AW'(ins_reg.slot_index);
        if (ins_reg.action == bpf64_pkg::ACT_EXEC) begin
            rec_ok_c = (k64 < 64'(record_width_reg)) && (k64 < 64'(RECORD_SLOTS));
            rec_addr = ins_reg.operand_k[REC_AW-1:0];
        end else begin
            rec_ok_c = 32'(ins_reg.slot_index) < 32'(RECORD_SLOTS);
            rec_addr = REC_AW'(ins_reg.slot_index);
        end
    end

    always_comb begin
        logic [1:0]  err;
        logic        done;
        logic [1:0]  req;
        logic [63:0] ret;
        logic [63:0] rd;
        logic [63:0] v;
        logic [63:0] ldv;
        logic [63:0] scr_v;
        logic [63:0] rec_v;
        logic [15:0] adv;
        logic        go_mul;
        logic        go_div;
        logic        tk;
        logic [2:0]  cls;
        logic [2:0]  mode;
        logic [3:0]  op;
        logic        sgt;
        logic        ge;
        logic [64:0] sh;
        logic [63:0] p_new;

        state_next = state_reg;
        a_next     = a_reg;
        x_next     = x_reg;
        pc_next    = pc_reg;
        res_next   = res_reg;
        wp_next    = wp_reg;
        wq_next    = wq_reg;
        wd_next    = wd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        add_x      = {1'b0, a_reg};
        add_y      = {1'b0, x_reg};
        add_ci     = 1'b0;
        scr_we     = 1'b0;
        col_we     = 1'b0;
        rec_we     = 1'b0;
        scr_clr    = 1'b0;
        wr_data    = a_reg;

        err    = bpf64_pkg::ERR_OK;
        done   = 1'b0;
        req    = bpf64_pkg::REQ_NONE;
        ret    = '0;
        rd     = '0;
        adv    = 16'd1;
        go_mul = 1'b0;
        go_div = 1'b0;
        tk     = 1'b0;
        ldv    = '0;
        ge     = 1'b0;
        sh     = '0;
        p_new  = wp_reg;
        cls    = ins_reg.opcode[2:0];
        mode   = ins_reg.opcode[7:5];
        op     = ins_reg.opcode[7:4];
        v      = ins_reg.opcode[3] ? x_reg : k64;
        sgt    = $signed(a_reg) > $signed(v);
        scr_v  = scr_rdv_reg ? scr_rd_reg : 64'd0;
        rec_v  = rec_rdv_reg ? rec_rd_reg : 64'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                case (ins_reg.action)
                    bpf64_pkg::ACT_EXEC: begin
                        case (cls)
                            bpf64_pkg::CLS_LD, bpf64_pkg::CLS_LDX: begin
                                if (ins_reg.opcode[4:3] != 2'd0) begin
                                    err = bpf64_pkg::ERR_ENC;
                                end else if (mode == bpf64_pkg::MODE_IMM) begin
                                    ldv = k64;
                                end else if (mode == bpf64_pkg::MODE_MEM) begin
                                    if (!scr_ok_reg) err = bpf64_pkg::ERR_RANGE;
                                    ldv = scr_v;
                                end else if (cls == bpf64_pkg::CLS_LD &&
                                             (mode == bpf64_pkg::MODE_ABS ||
                                              mode == bpf64_pkg::MODE_IND)) begin
                                    if (!col_ok_reg) err = bpf64_pkg::ERR_RANGE;
                                    ldv = col_rd_reg;
                                end else if (cls == bpf64_pkg::CLS_LD &&
                                             mode == bpf64_pkg::MODE_REC) begin
                                    if (!rec_ok_reg) err = bpf64_pkg::ERR_RANGE;
                                    ldv = rec_v;
                                end else begin
                                    err = bpf64_pkg::ERR_ENC;
                                end
                                if (err == bpf64_pkg::ERR_OK) begin
                                    if (cls == bpf64_pkg::CLS_LD) a_next = ldv;
                                    else x_next = ldv;
                                end
                            end
                            bpf64_pkg::CLS_ST, bpf64_pkg::CLS_STX: begin
                                wr_data = (cls == bpf64_pkg::CLS_ST) ? a_reg : x_reg;
                                if (mode == bpf64_pkg::MODE_MEM) begin
                                    if (!scr_ok_reg) err = bpf64_pkg::ERR_RANGE;
                                    else scr_we = 1'b1;
                                end else if (cls == bpf64_pkg::CLS_ST &&
                                             mode == bpf64_pkg::MODE_REC) begin
                                    if (!rec_ok_reg) err = bpf64_pkg::ERR_RANGE;
                                    else rec_we = 1'b1;
                                end else begin
                                    err = bpf64_pkg::ERR_ENC;
                                end
                            end
                            bpf64_pkg::CLS_ALU: begin
                                case (op)
                                    bpf64_pkg::ALU_ADD: begin
                                        add_y  = {1'b0, v};
                                        a_next = add_sum[63:0];
                                    end
                                    bpf64_pkg::ALU_SUB: begin
                                        add_y  = {1'b0, ~v};
                                        add_ci = 1'b1;
                                        a_next = add_sum[63:0];
                                    end
                                    bpf64_pkg::ALU_MUL: begin
                                        go_mul  = 1'b1;
                                        wp_next = '0;
                                        wd_next = a_reg;
                                        wq_next = v;
                                        cnt_next = '0;
                                    end
                                    bpf64_pkg::ALU_DIV: begin
                                        if (v == 64'd0) begin
                                            err = bpf64_pkg::ERR_DIV0;
                                        end else begin
                                            go_div   = 1'b1;
                                            wp_next  = '0;
                                            wq_next  = a_reg[63] ? (64'd0 - a_reg) : a_reg;
                                            wd_next  = v[63] ? (64'd0 - v) : v;
                                            neg_next = a_reg[63] ^ v[63];
                                            cnt_next = '0;
                                        end
                                    end
                                    bpf64_pkg::ALU_OR:  a_next = a_reg | v;
                                    bpf64_pkg::ALU_AND: a_next = a_reg & v;
                                    bpf64_pkg::ALU_LSH: a_next = a_reg << v[5:0];
                                    bpf64_pkg::ALU_RSH: a_next = 64'($signed(a_reg) >>> v[5:0]);
                                    bpf64_pkg::ALU_NEG: begin
                                        add_x  = {1'b0, ~a_reg};
                                        add_y  = '0;
                                        add_ci = 1'b1;
                                        a_next = add_sum[63:0];
                                    end
                                    default: err = bpf64_pkg::ERR_ENC;
                                endcase
                            end
                            bpf64_pkg::CLS_JMP: begin
                                case (op)
                                    bpf64_pkg::JMP_JA:   adv = 16'd1 + v[15:0];
                                    bpf64_pkg::JMP_JEQ:  tk = (a_reg == v);
                                    bpf64_pkg::JMP_JGT:  tk = sgt;
                                    bpf64_pkg::JMP_JGE:  tk = sgt || (a_reg == v);
                                    bpf64_pkg::JMP_JSET: tk = (a_reg & v) != 64'd0;
                                    default: err = bpf64_pkg::ERR_ENC;
                                endcase
                                if (op != bpf64_pkg::JMP_JA) begin
                                    adv = 16'd1 + 16'(tk ? ins_reg.jump_true
                                                         : ins_reg.jump_false);
                                end
                            end
                            bpf64_pkg::CLS_RET: begin
                                done = 1'b1;
                                case (ins_reg.opcode[4:3])
                                    bpf64_pkg::RVAL_K: ret = k64;
                                    bpf64_pkg::RVAL_X: ret = x_reg;
                                    bpf64_pkg::RVAL_A: ret = a_reg;
                                    default: err = bpf64_pkg::ERR_ENC;
                                endcase
                            end
                            default: begin
                                case (ins_reg.opcode[7:3])
                                    bpf64_pkg::MISC_TAX: x_next = a_reg;
                                    bpf64_pkg::MISC_TXA: a_next = x_reg;
                                    bpf64_pkg::MISC_LDR: req = bpf64_pkg::REQ_LOAD;
                                    bpf64_pkg::MISC_STR: req = bpf64_pkg::REQ_STORE;
                                    default: err = bpf64_pkg::ERR_ENC;
                                endcase
                            end
                        endcase
                        if (err != bpf64_pkg::ERR_OK) begin
                            done   = 1'b1;
                            ret    = '0;
                            req    = bpf64_pkg::REQ_NONE;
                            go_mul = 1'b0;
                            go_div = 1'b0;
                            scr_we = 1'b0;
                            rec_we = 1'b0;
                        end
                        if (done) begin
                            a_next  = '0;
                            x_next  = '0;
                            pc_next = '0;
                            scr_clr = 1'b1;
                        end else begin
                            pc_next = pc_reg + adv;
                        end
                    end
                    bpf64_pkg::ACT_COL_WRITE: begin
                        wr_data = ins_reg.word_value;
                        if (32'(ins_reg.slot_index) < 32'(COLUMN_SLOTS)) col_we = 1'b1;
                        else err = bpf64_pkg::ERR_RANGE;
                    end
                    bpf64_pkg::ACT_REC_WRITE: begin
                        wr_data = ins_reg.word_value;
                        if (rec_ok_reg) rec_we = 1'b1;
                        else err = bpf64_pkg::ERR_RANGE;
                    end
                    default: begin
                        if (rec_ok_reg) rd = rec_v;
                        else err = bpf64_pkg::ERR_RANGE;
                    end
                endcase
                res_next.next_pc      = pc_next;
                res_next.finished     = done;
                res_next.return_value = ret;
                res_next.misc_request = req;
                res_next.error_code   = err;
                res_next.read_value   = rd;
                if (go_mul) state_next = ST_MUL;
                else if (go_div) state_next = ST_DIV;
                else state_next = ST_WB;
            end
            ST_MUL: begin
                // shift-add, one multiplier bit per cycle
                add_x    = {1'b0, wp_reg};
                add_y    = {1'b0, wd_reg};
                p_new    = wq_reg[0] ? add_sum[63:0] : wp_reg;
                wp_next  = p_new;
                wd_next  = wd_reg << 1;
                wq_next  = wq_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    a_next     = p_new;
                    state_next = ST_WB;
                end
            end
            ST_DIV: begin
                // restoring division on magnitudes, one quotient bit per cycle
                sh       = {wp_reg, wq_reg[63]};
                add_x    = sh;
                add_y    = ~{1'b0, wd_reg};
                add_ci   = 1'b1;
                ge       = !add_sum[64];
                wp_next  = ge ? add_sum[63:0] : sh[63:0];
                wq_next  = {wq_reg[62:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                add_x  = {1'b0, ~wq_reg};
                add_y  = '0;
                add_ci = 1'b1;
                a_next = neg_reg ? add_sum[63:0] : wq_reg;
                state_next = ST_WB;
            end
            ST_WB: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            a_reg            <= '0;
            x_reg            <= '0;
            pc_reg           <= '0;
            column_count_reg <= '0;
            record_width_reg <= '0;
            scr_vld_reg      <= '0;
            rec_vld_reg      <= '0;
        end else begin
            state_reg <= state_next;
            a_reg     <= a_next;
            x_reg     <= x_next;
            pc_reg    <= pc_next;
            if (cfg_valid) begin
                if (cfg_index == bpf64_pkg::CFG_COLUMN_COUNT) begin
                    column_count_reg <= cfg_data[6:0];
                end else if (cfg_index == bpf64_pkg::CFG_RECORD_WIDTH) begin
                    record_width_reg <= cfg_data[4:0];
                end
            end
            if (scr_clr) begin
                scr_vld_reg <= '0;
            end else if (scr_we) begin
                scr_vld_reg[scr_addr] <= 1'b1;
            end
            if (rec_we) begin
                rec_vld_reg[rec_addr] <= 1'b1;
            end
            if (state_reg == ST_WB && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ins_reg <= s_data;
        end
        if (state_reg == ST_WB && (!m_valid_reg || m_ready)) begin
            out_reg <= res_reg;
        end
        res_reg     <= res_next;
        wp_reg      <= wp_next;
        wq_reg      <= wq_next;
        wd_reg      <= wd_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        col_ok_reg  <= col_ok_c;
        scr_ok_reg  <= scr_ok_c;
        rec_ok_reg  <= rec_ok_c;
    end

    // scratch, column and record stores
    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[scr_addr] <= wr_data;
        end
        scr_rd_reg  <= scr_mem[scr_addr];
        scr_rdv_reg <= scr_vld_reg[scr_addr];
    end

    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[col_waddr] <= wr_data;
        end
        col_rd_reg <= col_mem[col_raddr];
    end

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_addr] <= wr_data;
        end
        rec_rd_reg  <= rec_mem[rec_addr];
        rec_rdv_reg <= rec_vld_reg[rec_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bpf64_checker.sv -----
`default_nettype none

module bpf64_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire bpf64_pkg::out_t m_data
);

    // result channel empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // a finished run restarts from pc zero
    a_end_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.finished |-> m_data.next_pc == 16'd0)
        else $error("finished run with nonzero pc");

    // return value only on a finished run
    a_ret_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.finished |-> m_data.return_value == 64'sd0)
        else $error("return value without finish");

endmodule

bind bpf64_instruction_executor bpf64_checker u_bpf64_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
